/* rtl/irb_pkg.sv */
// Package for the bilinear image rotation block.
// Holds payload structs, command codes and the quarter-wave sine table.
// Depends on nothing.
package irb_pkg;

    typedef enum logic {
        CMD_WRITE   = 1'b0,
        CMD_COMPUTE = 1'b1
    } t_cmd;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ANGLE  = 2'd2;

    typedef struct packed {
        logic       command;
        logic [7:0] column;
        logic [7:0] row;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       inside_res;
    } t_out_item;

    // Rounded sin(d) * 2^14 for d = 0..90 degrees.
    function automatic logic [14:0] quarter_sin(input logic [6:0] d);
        logic [14:0] v;
        case (d)
            7'd0: v = 15'd0;       7'd1: v = 15'd286;     7'd2: v = 15'd572;
            7'd3: v = 15'd857;     7'd4: v = 15'd1143;    7'd5: v = 15'd1428;
            7'd6: v = 15'd1713;    7'd7: v = 15'd1997;    7'd8: v = 15'd2280;
            7'd9: v = 15'd2563;    7'd10: v = 15'd2845;   7'd11: v = 15'd3126;
            7'd12: v = 15'd3406;   7'd13: v = 15'd3686;   7'd14: v = 15'd3964;
            7'd15: v = 15'd4240;   7'd16: v = 15'd4516;   7'd17: v = 15'd4790;
            7'd18: v = 15'd5063;   7'd19: v = 15'd5334;   7'd20: v = 15'd5604;
            7'd21: v = 15'd5872;   7'd22: v = 15'd6138;   7'd23: v = 15'd6402;
            7'd24: v = 15'd6664;   7'd25: v = 15'd6924;   7'd26: v = 15'd7182;
            7'd27: v = 15'd7438;   7'd28: v = 15'd7692;   7'd29: v = 15'd7943;
            7'd30: v = 15'd8192;   7'd31: v = 15'd8438;   7'd32: v = 15'd8682;
            7'd33: v = 15'd8923;   7'd34: v = 15'd9162;   7'd35: v = 15'd9397;
            7'd36: v = 15'd9630;   7'd37: v = 15'd9860;   7'd38: v = 15'd10087;
            7'd39: v = 15'd10311;  7'd40: v = 15'd10531;  7'd41: v = 15'd10749;
            7'd42: v = 15'd10963;  7'd43: v = 15'd11174;  7'd44: v = 15'd11381;
            7'd45: v = 15'd11585;  7'd46: v = 15'd11786;  7'd47: v = 15'd11982;
            7'd48: v = 15'd12176;  7'd49: v = 15'd12365;  7'd50: v = 15'd12551;
            7'd51: v = 15'd12733;  7'd52: v = 15'd12911;  7'd53: v = 15'd13085;
            7'd54: v = 15'd13255;  7'd55: v = 15'd13421;  7'd56: v = 15'd13583;
            7'd57: v = 15'd13741;  7'd58: v = 15'd13894;  7'd59: v = 15'd14044;
            7'd60: v = 15'd14189;  7'd61: v = 15'd14330;  7'd62: v = 15'd14466;
            7'd63: v = 15'd14598;  7'd64: v = 15'd14726;  7'd65: v = 15'd14849;
            7'd66: v = 15'd14968;  7'd67: v = 15'd15082;  7'd68: v = 15'd15191;
            7'd69: v = 15'd15296;  7'd70: v = 15'd15396;  7'd71: v = 15'd15491;
            7'd72: v = 15'd15582;  7'd73: v = 15'd15668;  7'd74: v = 15'd15749;
            7'd75: v = 15'd15826;  7'd76: v = 15'd15897;  7'd77: v = 15'd15964;
            7'd78: v = 15'd16026;  7'd79: v = 15'd16083;  7'd80: v = 15'd16135;
            7'd81: v = 15'd16182;  7'd82: v = 15'd16225;  7'd83: v = 15'd16262;
            7'd84: v = 15'd16294;  7'd85: v = 15'd16322;  7'd86: v = 15'd16344;
            7'd87: v = 15'd16362;  7'd88: v = 15'd16374;  7'd89: v = 15'd16382;
            7'd90: v = 15'd16384;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    // Signed Q1.14 sine for a reduced angle of 0..359 degrees.
    function automatic logic signed [15:0] sin_deg(input logic [8:0] r);
        logic [14:0] m;
        logic        neg;
        m   = '0;
        neg = 1'b0;
        if (r <= 9'd90) begin
            m = quarter_sin(r[6:0]);
        end else if (r <= 9'd180) begin
            m = quarter_sin(7'(9'd180 - r));
        end else if (r <= 9'd270) begin
            m   = quarter_sin(7'(r - 9'd180));
            neg = 1'b1;
        end else begin
            m   = quarter_sin(7'(9'd360 - r));
            neg = 1'b1;
        end
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

endpackage

/* rtl/irb_blend.sv */
// Pipelined bilinear blend of one 8-bit channel over three register stages.
// Depends on nothing but its ports.
module irb_blend (
    input  logic       i_clk,
    input  logic [7:0] i_p00,
    input  logic [7:0] i_p10,
    input  logic [7:0] i_p01,
    input  logic [7:0] i_p11,
    input  logic [7:0] i_fx,
    input  logic [7:0] i_fy,
    output logic [7:0] o_pix
);

    logic [16:0] r_top;
    logic [16:0] r_bot;
    logic [7:0]  r_fy;
    logic [25:0] r_top_w;
    logic [25:0] r_bot_w;
    logic [8:0]  w_fxc;
    logic [8:0]  w_fyc;

    assign w_fxc = 9'd256 - {1'b0, i_fx};
    assign w_fyc = 9'd256 - {1'b0, r_fy};

    // Horizontal blend, then vertical weighting, then the final sum.
    always_ff @(posedge i_clk) begin
        r_top   <= 17'(i_p00) * 17'(w_fxc) + 17'(i_p10) * 17'(i_fx);
        r_bot   <= 17'(i_p01) * 17'(w_fxc) + 17'(i_p11) * 17'(i_fx);
        r_fy    <= i_fy;
        r_top_w <= 26'(r_top) * 26'(w_fyc);
        r_bot_w <= 26'(r_bot) * 26'(r_fy);
        o_pix   <= 8'((r_top_w + r_bot_w) >> 16);
    end

endmodule

/* rtl/image_rotate_bilinear_top.sv */
// Top level of the bilinear image rotation block.
// Uses irb_pkg and irb_blend; holds the source frame as four banked copies.
//
//  Channel  | Ports                          | Handshake
//  ---------+--------------------------------+----------------------------
//  command  | i_start, o_busy, i_item        | start high while busy low
//  result   | o_result_valid, o_result       | one-cycle strobe, no stall
//  config   | i_cfg_we, i_cfg_index, i_cfg_data | write when enable high
//
// One command enters every cycle; o_busy is always low. A compute command
// passes the offset, product and sum stages of the rotation, the frame read,
// the three blend stages and the output register. A write reaches the
// frame through delay registers, in step with the neighbor reads, so every
// command sees exactly the writes sent before it. Reset loads the config
// defaults and clears the valid and write-enable bits; the frame holds
// garbage until written. The receiver cannot stall, so no result waits.
module image_rotate_bilinear_top
    import irb_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    output logic      o_busy,
    input  t_in_item  i_item,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [9:0] i_cfg_data,
    output logic      o_result_valid,
    output t_out_item o_result
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;

    // Configuration registers.
    logic [8:0] r_width;
    logic [8:0] r_height;
    logic [9:0] r_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 9'd256;
            r_angle  <= 10'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data[8:0];
                REG_HEIGHT: r_height <= i_cfg_data[8:0];
                REG_ANGLE:  r_angle  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Saturated sizes, reduced angle and trig values, worked out from the registers.
    logic [12:0] w_w;
    logic [12:0] w_h;
    logic signed [10:0] w_a;
    logic signed [10:0] w_am;
    logic [8:0]  w_r;
    logic [8:0]  w_rc;

    always_comb begin
        w_w = (r_width == 9'd0) ? 13'd1 : 13'(r_width);
        if (w_w > 13'(MAX_WIDTH)) w_w = 13'(MAX_WIDTH);
        w_h = (r_height == 9'd0) ? 13'd1 : 13'(r_height);
        if (w_h > 13'(MAX_HEIGHT)) w_h = 13'(MAX_HEIGHT);
        w_a  = 11'($signed(r_angle));
        w_am = w_a;
        if (w_a >= 11'sd360) w_am = w_a - 11'sd360;
        else if (w_a < 11'sd0) w_am = w_a + 11'sd360;
        if (w_am < 11'sd0) w_am = w_am + 11'sd360;
        w_r  = w_am[8:0];
        w_rc = (w_r >= 9'd270) ? w_r - 9'd270 : w_r + 9'd90;
    end

    logic signed [15:0] r_sin;
    logic signed [15:0] r_cos;
    logic [12:0] r_wm1;
    logic [12:0] r_hm1;

    always_ff @(posedge i_clk) begin
        r_sin <= sin_deg(w_r);
        r_cos <= sin_deg(w_rc);
        r_wm1 <= w_w - 13'd1;
        r_hm1 <= w_h - 13'd1;
    end

    assign o_busy = 1'b0;

    // Stage 1: accept, form centered doubled offsets from the current sizes.
    logic        w_acc;
    logic        r_v1;
    logic [7:0]  r_col1;
    logic [7:0]  r_row1;
    logic signed [14:0] r_dx1;
    logic signed [14:0] r_dy1;

    assign w_acc = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= w_acc && (i_item.command == CMD_COMPUTE);
        r_col1 <= i_item.column;
        r_row1 <= i_item.row;
        r_dx1  <= $signed({6'd0, i_item.column, 1'b0}) - $signed({2'b0, w_w - 13'd1});
        r_dy1  <= $signed({6'd0, i_item.row, 1'b0}) - $signed({2'b0, w_h - 13'd1});
    end

    // Stage 2: the four products.
    logic        r_v2;
    logic [7:0]  r_col2;
    logic [7:0]  r_row2;
    logic signed [31:0] r_cx;
    logic signed [31:0] r_sy;
    logic signed [31:0] r_sx;
    logic signed [31:0] r_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= r_v1;
        r_col2 <= r_col1;
        r_row2 <= r_row1;
        r_cx   <= 32'(r_cos) * 32'(r_dx1);
        r_sy   <= 32'(r_sin) * 32'(r_dy1);
        r_sx   <= 32'(r_sin) * 32'(r_dx1);
        r_cy   <= 32'(r_cos) * 32'(r_dy1);
    end

    // Stage 3: sums, floor to Q8, neighbor check.
    logic signed [31:0] w_x15;
    logic signed [31:0] w_y15;
    logic signed [24:0] w_x8;
    logic signed [24:0] w_y8;
    logic signed [16:0] w_x0;
    logic signed [16:0] w_y0;
    logic        w_in;

    assign w_x15 = r_cx - r_sy + $signed({5'd0, r_wm1, 14'd0});
    assign w_y15 = r_sx + r_cy + $signed({5'd0, r_hm1, 14'd0});
    assign w_x8  = w_x15[31:7];
    assign w_y8  = w_y15[31:7];
    assign w_x0  = w_x8[24:8];
    assign w_y0  = w_y8[24:8];
    assign w_in  = !w_x0[16] && !w_y0[16]
                && (w_x0 + 17'sd1 < $signed({4'd0, r_wm1 + 13'd1}))
                && (w_y0 + 17'sd1 < $signed({4'd0, r_hm1 + 13'd1}));

    logic        r_v3;
    logic        r_in3;
    logic [XW-1:0] r_x3;
    logic [YW-1:0] r_y3;
    logic [7:0]  r_fx3;
    logic [7:0]  r_fy3;
    logic [7:0]  r_col3;
    logic [7:0]  r_row3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= r_v2;
        r_in3  <= w_in;
        r_x3   <= XW'(w_x0);
        r_y3   <= YW'(w_y0);
        r_fx3  <= w_x8[7:0];
        r_fy3  <= w_y8[7:0];
        r_col3 <= r_col2;
        r_row3 <= r_row2;
    end

    // Frame store: four copies, one read port each; the pass-through pixel
    // comes from the first copy when out of bounds.
    logic [23:0] r_mem00 [DEPTH];
    logic [23:0] r_mem10 [DEPTH];
    logic [23:0] r_mem01 [DEPTH];
    logic [23:0] r_mem11 [DEPTH];
    logic        w_wr;
    logic        w_wr_ok;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_a00;
    logic [AW-1:0] w_a10;
    logic [AW-1:0] w_a01;
    logic [AW-1:0] w_a11;
    logic        w_pin;

    assign w_wr_ok = (32'(i_item.column) < 32'(MAX_WIDTH))
                  && (32'(i_item.row) < 32'(MAX_HEIGHT));
    assign w_wr    = w_acc && (i_item.command == CMD_WRITE) && w_wr_ok;
    assign w_waddr = {XW'(i_item.column), YW'(i_item.row)};
    assign w_pin   = (32'(r_col3) < 32'(MAX_WIDTH)) && (32'(r_row3) < 32'(MAX_HEIGHT));
    assign w_a00   = r_in3 ? {r_x3, r_y3} : {XW'(r_col3), YW'(r_row3)};
    assign w_a10   = {r_x3 + XW'(1), r_y3};
    assign w_a01   = {r_x3, r_y3 + YW'(1)};
    assign w_a11   = {r_x3 + XW'(1), r_y3 + YW'(1)};

    // Write transfers travel three stages so they land in command order.
    logic [2:0]    r_wr_d;
    logic [AW-1:0] r_wa1;
    logic [AW-1:0] r_wa2;
    logic [AW-1:0] r_wa3;
    logic [23:0]   r_wd1;
    logic [23:0]   r_wd2;
    logic [23:0]   r_wd3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_wr_d <= '0;
        else          r_wr_d <= {r_wr_d[1:0], w_wr};
        r_wa1 <= w_waddr;
        r_wa2 <= r_wa1;
        r_wa3 <= r_wa2;
        r_wd1 <= {i_item.in_red, i_item.in_green, i_item.in_blue};
        r_wd2 <= r_wd1;
        r_wd3 <= r_wd2;
    end

    logic [23:0] r_p00;
    logic [23:0] r_p10;
    logic [23:0] r_p01;
    logic [23:0] r_p11;

    always_ff @(posedge i_clk) begin
        if (r_wr_d[2]) begin
            r_mem00[r_wa3] <= r_wd3;
            r_mem10[r_wa3] <= r_wd3;
            r_mem01[r_wa3] <= r_wd3;
            r_mem11[r_wa3] <= r_wd3;
        end
        r_p00 <= r_mem00[w_a00];
        r_p10 <= r_mem10[w_a10];
        r_p01 <= r_mem01[w_a01];
        r_p11 <= r_mem11[w_a11];
    end

    // Stage 4: read data valid; carry control to the blend output.
    logic [3:0] r_v_d;
    logic [3:0] r_in_d;
    logic [3:0] r_pin_d;
    logic [7:0] r_fx4;
    logic [7:0] r_fy4;
    logic [23:0] r_pass5;
    logic [23:0] r_pass6;
    logic [23:0] r_pass7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v_d <= '0;
        else          r_v_d <= {r_v_d[2:0], r_v3};
        r_in_d  <= {r_in_d[2:0], r_in3};
        r_pin_d <= {r_pin_d[2:0], w_pin};
        r_fx4   <= r_fx3;
        r_fy4   <= r_fy3;
        r_pass5 <= r_p00;
        r_pass6 <= r_pass5;
        r_pass7 <= r_pass6;
    end

    logic [7:0] w_bl [3];

    for (genvar g = 0; g < 3; g++) begin : g_ch
        irb_blend u_blend (
            .i_clk (i_clk),
            .i_p00 (r_p00[16-8*g +: 8]),
            .i_p10 (r_p10[16-8*g +: 8]),
            .i_p01 (r_p01[16-8*g +: 8]),
            .i_p11 (r_p11[16-8*g +: 8]),
            .i_fx  (r_fx4),
            .i_fy  (r_fy4),
            .o_pix (w_bl[g])
        );
    end

    // Output register: blend, pass-through, or zero outside the frame store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_result_valid <= 1'b0;
        else          o_result_valid <= r_v_d[3];
        if (r_in_d[3]) begin
            o_result <= {w_bl[0], w_bl[1], w_bl[2], 1'b1};
        end else if (r_pin_d[3]) begin
            o_result <= {r_pass7, 1'b0};
        end else begin
            o_result <= '0;
        end
    end

endmodule

/* bench/image_rotate_bilinear_top_tb.sv */
// Self-checking testbench for image_rotate_bilinear_top.
// Drives write and compute commands, predicts each rotated pixel and compares it.
// Depends on irb_pkg and the image_rotate_bilinear_top RTL.
module image_rotate_bilinear_top_tb;
    import irb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    logic       o_busy;
    t_in_item   i_item;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [9:0] i_cfg_data;
    logic       o_result_valid;
    t_out_item  o_result;

    image_rotate_bilinear_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_item        (i_item),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_result_valid(o_result_valid),
        .o_result      (o_result)
    );

    // Shadow state of the block.
    bit [23:0] frame_pix [65536];
    bit        frame_written [65536];
    int        sin_quarter [91];
    bit [8:0]  width_reg;
    bit [8:0]  height_reg;
    bit [9:0]  angle_reg;

    t_out_item pixel_queue[$];
    int        error_count;
    int        write_count;
    int        compute_count;
    int        inside_count;
    int        idle_cycles;
    bit        gaps_on;

    always #5 i_clk = ~i_clk;

    function automatic int sin_q14(int r);
        if (r <= 90) return sin_quarter[r];
        if (r <= 180) return sin_quarter[180 - r];
        if (r <= 270) return -sin_quarter[r - 180];
        return -sin_quarter[360 - r];
    endfunction

    // Rotated pixel for a compute command; ok is low if an unwritten entry would be read.
    function automatic void rotate_pixel(input t_in_item it, output t_out_item res,
                                         output bit ok);
        longint w, h, dx2, dy2, x15, y15, x8, y8, x0, y0, fx, fy;
        longint top, bot;
        int     a, s, c, k, ch;
        bit [23:0] p [4];
        w = (width_reg == 0) ? 1 : (width_reg > 256 ? 256 : width_reg);
        h = (height_reg == 0) ? 1 : (height_reg > 256 ? 256 : height_reg);
        a = $signed(angle_reg);
        a = a % 360;
        if (a < 0) a += 360;
        s = sin_q14(a);
        c = sin_q14((a + 90) % 360);
        dx2 = 2 * longint'(it.column) - (w - 1);
        dy2 = 2 * longint'(it.row) - (h - 1);
        x15 = c * dx2 - s * dy2 + (w - 1) * 16384;
        y15 = s * dx2 + c * dy2 + (h - 1) * 16384;
        x8 = x15 >>> 7;
        y8 = y15 >>> 7;
        x0 = x8 >>> 8;
        y0 = y8 >>> 8;
        ok = 1'b1;
        if (x0 >= 0 && x0 + 1 < w && y0 >= 0 && y0 + 1 < h) begin
            fx = x8 & 255;
            fy = y8 & 255;
            for (k = 0; k < 4; k++) begin
                p[k] = frame_pix[(x0 + k % 2) * 256 + y0 + k / 2];
                if (!frame_written[(x0 + k % 2) * 256 + y0 + k / 2]) ok = 1'b0;
            end
            for (ch = 0; ch < 3; ch++) begin
                top = longint'(p[0][16 - 8 * ch +: 8]) * (256 - fx)
                    + longint'(p[1][16 - 8 * ch +: 8]) * fx;
                bot = longint'(p[2][16 - 8 * ch +: 8]) * (256 - fx)
                    + longint'(p[3][16 - 8 * ch +: 8]) * fx;
                p[0][16 - 8 * ch +: 8] = 8'((top * (256 - fy) + bot * fy) >> 16);
            end
            res = '{p[0][23:16], p[0][15:8], p[0][7:0], 1'b1};
        end else begin
            k = int'(it.column) * 256 + int'(it.row);
            ok = frame_written[k];
            res = '{frame_pix[k][23:16], frame_pix[k][15:8], frame_pix[k][7:0], 1'b0};
        end
    endfunction

    // One command transfer, at times with a random idle gap in front of it.
    task automatic send_item(input t_in_item it);
        t_out_item res;
        bit ok;
        if (gaps_on && $urandom_range(99) < 13) begin
            i_start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_item  = it;
        i_start = 1'b1;
        do @(posedge i_clk); while (o_busy);
        if (it.command == CMD_WRITE) begin
            frame_pix[int'(it.column) * 256 + int'(it.row)] =
                {it.in_red, it.in_green, it.in_blue};
            frame_written[int'(it.column) * 256 + int'(it.row)] = 1'b1;
            write_count++;
        end else begin
            rotate_pixel(it, res, ok);
            pixel_queue.push_back(res);
            compute_count++;
            if (res.inside_res) inside_count++;
        end
        @(negedge i_clk);
        i_start = 1'b0;
        i_item  = t_in_item'({$urandom, $urandom});
    endtask

    task automatic write_pixel(input int col, input int row, input bit [23:0] rgb);
        t_in_item it;
        it = '{CMD_WRITE, 8'(col), 8'(row), rgb[23:16], rgb[15:8], rgb[7:0]};
        send_item(it);
    endtask

    // A compute command is only sent when it reads written entries.
    task automatic compute_pixel(input int col, input int row);
        t_in_item  it;
        t_out_item res;
        bit        ok;
        it = '{CMD_COMPUTE, 8'(col), 8'(row), 8'($urandom), 8'($urandom), 8'($urandom)};
        rotate_pixel(it, res, ok);
        if (ok) send_item(it);
    endtask

    // Waits until the pipeline is empty, then writes one register.
    task automatic write_register(input logic [1:0] idx, input logic [9:0] data);
        wait (pixel_queue.size() == 0);
        repeat (10) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_WIDTH:  width_reg  = data[8:0];
            REG_HEIGHT: height_reg = data[8:0];
            REG_ANGLE:  angle_reg  = data;
            default: ;
        endcase
    endtask

    task automatic fill_block(input int c0, input int r0, input int nc, input int nr);
        for (int c = c0; c < c0 + nc && c < 256; c++)
            for (int r = r0; r < r0 + nr && r < 256; r++)
                write_pixel(c, r, 24'($urandom));
    endtask

    function automatic bit compute_ok(input int col, input int row);
        t_in_item  it;
        t_out_item res;
        bit        ok;
        it = '{CMD_COMPUTE, 8'(col), 8'(row), 8'd0, 8'd0, 8'd0};
        rotate_pixel(it, res, ok);
        return ok;
    endfunction

    // Extremes of the fields, pass-through at the edges and outside the image.
    task automatic test_directed();
        write_register(REG_WIDTH, 10'd3);
        write_register(REG_HEIGHT, 10'd3);
        write_pixel(0, 0, 24'hFFFFFF);
        write_pixel(1, 0, 24'h000000);
        write_pixel(0, 1, 24'hFF00FF);
        write_pixel(1, 1, 24'h00FF00);
        write_pixel(255, 255, 24'hA5C3FF);
        write_pixel(2, 2, 24'h123456);
        compute_pixel(0, 0);
        compute_pixel(2, 2);
        compute_pixel(255, 255);
        write_register(REG_ANGLE, 10'd90);
        fill_block(0, 0, 3, 3);
        compute_pixel(1, 1);
        compute_pixel(0, 2);
        compute_pixel(2, 0);
    endtask

    // Several geometries; each fills a block and then mixes computes with noise writes.
    task automatic test_rotation_sweep();
        int dims [7][3] = '{
            '{4, 4, 45}, '{1, 1, 511}, '{2, 2, 512}, '{16, 9, 360},
            '{8, 12, 1023}, '{511, 0, 180}, '{256, 256, 0}
        };
        int nc, nr, col, row, tries;
        for (int ph = 0; ph < 7; ph++) begin
            gaps_on = (ph != 3);
            write_register(REG_WIDTH, 10'(dims[ph][0]));
            write_register(REG_HEIGHT, 10'(dims[ph][1]));
            write_register(REG_ANGLE, 10'(dims[ph][2]));
            nc = dims[ph][0] > 256 ? 256 : (dims[ph][0] < 1 ? 1 : dims[ph][0]);
            nr = dims[ph][1] > 256 ? 256 : (dims[ph][1] < 1 ? 1 : dims[ph][1]);
            if (nc > 16) begin
                fill_block(0, 0, 8, 8);
                fill_block(248, 248, 8, 8);
            end else begin
                fill_block(0, 0, nc, nr);
            end
            for (int n = 0; n < 70; n++) begin
                if ($urandom_range(99) < 30) begin
                    write_pixel($urandom_range(255), $urandom_range(255), 24'($urandom));
                end else begin
                    tries = 0;
                    do begin
                        col = $urandom_range(3) == 0 ? $urandom_range(255)
                            : $urandom_range(nc > 16 ? 255 : nc - 1);
                        row = $urandom_range(3) == 0 ? $urandom_range(255)
                            : $urandom_range(nr > 16 ? 255 : nr - 1);
                        if (nc > 16 && $urandom_range(1)) begin
                            col = $urandom_range(7) + ($urandom_range(1) ? 248 : 0);
                            row = $urandom_range(7) + ($urandom_range(1) ? 248 : 0);
                        end
                        tries++;
                    end while (tries < 64 && !compute_ok(col, row));
                    compute_pixel(col, row);
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    // Each result transfer is checked against the oldest expected pixel.
    always @(posedge i_clk) begin
        t_out_item exp_pix;
        if (i_rst_n && o_result_valid) begin
            if (pixel_queue.size() == 0) begin
                $error("unexpected result %h", o_result);
                error_count++;
            end else begin
                exp_pix = pixel_queue.pop_front();
                if (o_result.out_red !== exp_pix.out_red) begin
                    $error("out_red exp %h got %h", exp_pix.out_red, o_result.out_red);
                    error_count++;
                end
                if (o_result.out_green !== exp_pix.out_green) begin
                    $error("out_green exp %h got %h", exp_pix.out_green, o_result.out_green);
                    error_count++;
                end
                if (o_result.out_blue !== exp_pix.out_blue) begin
                    $error("out_blue exp %h got %h", exp_pix.out_blue, o_result.out_blue);
                    error_count++;
                end
                if (o_result.inside_res !== exp_pix.inside_res) begin
                    $error("inside_res exp %b got %b", exp_pix.inside_res,
                           o_result.inside_res);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_result_valid || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT) begin
                $display("[image_rotate_bilinear_top] ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_WIDTH;
        i_cfg_data  = '0;
        width_reg   = 9'd256;
        height_reg  = 9'd256;
        angle_reg   = '0;
        gaps_on     = 1'b1;
        for (int d = 0; d <= 90; d++)
            sin_quarter[d] = $rtoi($floor($sin(d * 3.14159265358979323846 / 180.0)
                                          * 16384.0 + 0.5));
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_rotation_sweep();
        wait (pixel_queue.size() == 0);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d pixel writes and %0d rotations, %0d of them interpolated,",
                 write_count, compute_count, inside_count);
        $display("over eight image sizes and angles from -512 to 511 degrees.");
        if (error_count == 0 && pixel_queue.size() == 0) begin
            $display("[image_rotate_bilinear_top] OK");
        end else begin
            $display("[image_rotate_bilinear_top] ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/irb_pkg.sv
rtl/irb_blend.sv
rtl/image_rotate_bilinear_top.sv
bench/image_rotate_bilinear_top_tb.sv
